### design/open_address_hash_table_defines.svh
`ifndef OPEN_ADDRESS_HASH_TABLE_DEFINES_SVH
`define OPEN_ADDRESS_HASH_TABLE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define OAHT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define OAHT_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/oaht_pkg.sv
package oaht_pkg;

    localparam int KEY_W     = 31;
    localparam int CFG_W     = 8;
    localparam int STAT_W    = 3;
    localparam int SLOT_W    = 7;
    localparam int PROBE_W   = 8;
    localparam int STEP_W    = 5;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // Bit counts for the two remainder passes: key mod divisor, then mod slots in use.
    localparam logic [STEP_W-1:0] STEPS_HOME = STEP_W'(KEY_W);
    localparam logic [STEP_W-1:0] STEPS_WRAP = STEP_W'(CFG_W);

    typedef logic [STAT_W-1:0] t_status;
    localparam t_status STAT_FOUND    = 3'd0;
    localparam t_status STAT_INSERTED = 3'd1;
    localparam t_status STAT_ABSENT   = 3'd2;
    localparam t_status STAT_FULL     = 3'd3;
    localparam t_status STAT_INVALID  = 3'd4;

    localparam logic REG_TABLE_SIZE = 1'b0;
    localparam logic REG_DIVISOR    = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HOME,
        S_WRAP,
        S_READ,
        S_CHECK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [CFG_W-1:0] table_size;
        logic [CFG_W-1:0] divisor;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [CFG_W-1:0]  divisor;
        logic [KEY_W-1:0]  dividend;
    } t_rem_req;

    typedef struct packed {
        logic             done;
        logic [CFG_W-1:0] rem;
    } t_rem_rsp;

endpackage

### design/oaht_req_if.sv
interface oaht_req_if;
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [oaht_pkg::KEY_W-1:0] key;

    modport source (output valid, output func, output key, input ready);
    modport sink (input valid, input func, input key, output ready);
endinterface

### design/oaht_rsp_if.sv
interface oaht_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [oaht_pkg::STAT_W-1:0]  status;
    logic [oaht_pkg::SLOT_W-1:0]  slot;
    logic [oaht_pkg::PROBE_W-1:0] probes;

    modport source (output valid, output status, output slot, output probes, input ready);
    modport sink (input valid, input status, input slot, input probes, output ready);
endinterface

### design/oaht_cfg.sv
module oaht_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [oaht_pkg::APB_AW-1:0]   i_paddr,
    input  logic [oaht_pkg::APB_DW-1:0]   i_pwdata,
    output logic [oaht_pkg::APB_DW-1:0]   o_prdata,
    output logic                          o_pready,
    output oaht_pkg::t_cfg                o_cfg
);
    import oaht_pkg::*;

    logic [CFG_W-1:0] r_table_size;
    logic [CFG_W-1:0] r_divisor;
    logic             wr_en;

    assign o_pready = 1'b1;
    assign wr_en    = i_psel & i_penable & i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= 8'd128;
            r_divisor    <= 8'd127;
        end else if (wr_en) begin
            case (i_paddr[2])
                REG_TABLE_SIZE: r_table_size <= i_pwdata[CFG_W-1:0];
                REG_DIVISOR:    r_divisor    <= i_pwdata[CFG_W-1:0];
                default:        r_table_size <= r_table_size;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[2])
            REG_TABLE_SIZE: o_prdata = APB_DW'(r_table_size);
            REG_DIVISOR:    o_prdata = APB_DW'(r_divisor);
            default:        o_prdata = '0;
        endcase
    end

    assign o_cfg.table_size = r_table_size;
    assign o_cfg.divisor    = r_divisor;
endmodule

### design/oaht_rem.sv
`include "open_address_hash_table_defines.svh"

module oaht_rem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  oaht_pkg::t_rem_req i_req,
    output oaht_pkg::t_rem_rsp o_rsp
);
    import oaht_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [KEY_W-1:0]  r_sh;
    logic [CFG_W-1:0]  r_rem;
    logic [CFG_W-1:0]  r_div;
    logic [CFG_W:0]    trial;
    logic [CFG_W-1:0]  n_rem;

    // Restoring remainder, one dividend bit per cycle, most significant first.
    always_comb begin
        trial = {r_rem, r_sh[KEY_W-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = CFG_W'(trial - {1'b0, r_div});
        end else begin
            n_rem = trial[CFG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sh  <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_sh  <= {r_sh[KEY_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

    `OAHT_ASSERT_IMP(a_rem_below_div, r_busy, r_rem < r_div, "partial remainder not below divisor")
    `OAHT_ASSERT_IMP(a_done_idle, r_done, !r_busy, "remainder done while still stepping")
endmodule

### design/oaht_mem.sv
module oaht_mem #(
    parameter int  DEPTH = 128,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [oaht_pkg::KEY_W-1:0] i_wdata,
    input  logic [AW-1:0]              i_raddr,
    output logic [oaht_pkg::KEY_W-1:0] o_rdata
);
    import oaht_pkg::*;

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### design/open_address_hash_table.sv
// Flow: a nonzero key takes its remainder by the divisor, then by the slots in use, and then
// a read and a compare per probe; a zero key goes straight to its word without a probe.
// Items: one at a time, paced by the bit-serial remainder unit and a read-and-compare per
// probe on the single key memory; the next item is taken once the last word is registered.
// Reset: synchronous, active low; afterwards the key memory is cleared one entry per cycle,
// and no input is taken until every entry is clear; configuration writes are still taken.
`include "open_address_hash_table_defines.svh"

module open_address_hash_table #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    oaht_req_if.sink                    i_req,
    oaht_rsp_if.source                  o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [oaht_pkg::APB_AW-1:0] paddr,
    input  logic [oaht_pkg::APB_DW-1:0] pwdata,
    output logic [oaht_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import oaht_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    // A probe position is always below the slots in use, which never exceed 255.
    localparam int PW = (AW < CFG_W) ? AW : CFG_W;

    t_cfg     cfg;
    t_rem_req rem_req;
    t_rem_rsp rem_rsp;

    t_state              r_state;
    t_state              n_state;
    logic [AW-1:0]       r_clr;
    logic                r_func;
    logic [KEY_W-1:0]    r_key;
    logic [PW-1:0]       r_pos;
    logic [PROBE_W-1:0]  r_coll;
    t_status             r_res_status;
    logic [SLOT_W-1:0]   r_res_slot;
    logic [PROBE_W-1:0]  r_res_probes;
    logic                r_ovalid;
    t_status             r_o_status;
    logic [SLOT_W-1:0]   r_o_slot;
    logic [PROBE_W-1:0]  r_o_probes;

    logic [CFG_W-1:0]    n_eff;
    logic [CFG_W-1:0]    d_eff;
    logic                in_acc;
    logic                out_free;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [KEY_W-1:0]    mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic [KEY_W-1:0]    mem_rdata;
    logic                hit;
    logic                empty;
    logic [PROBE_W-1:0]  coll_n;
    logic [CFG_W:0]      pos_sum;
    logic [CFG_W:0]      pos_wrap;
    logic [PW-1:0]       n_pos;
    logic                give_up;

    oaht_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    oaht_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rem_req),
        .o_rsp   (rem_rsp)
    );

    oaht_mem #(
        .DEPTH (TABLE_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Effective slot count and divisor after clamping the register values.
    always_comb begin
        if (cfg.table_size == '0) begin
            n_eff = CFG_W'(1);
        end else if (32'(cfg.table_size) > TABLE_DEPTH) begin
            n_eff = CFG_W'(TABLE_DEPTH);
        end else begin
            n_eff = cfg.table_size;
        end
        d_eff = (cfg.divisor == '0) ? CFG_W'(1) : cfg.divisor;
    end

    assign in_acc   = i_req.valid & i_req.ready;
    assign out_free = !r_ovalid || o_rsp.ready;

    // Probe datapath: compare the word read last cycle and form the next triangular step.
    always_comb begin
        hit      = (mem_rdata == r_key);
        empty    = (mem_rdata == '0);
        coll_n   = r_coll + 1'b1;
        give_up  = (coll_n >= n_eff);
        pos_sum  = (CFG_W + 1)'(r_pos) + (CFG_W + 1)'(coll_n);
        pos_wrap = (pos_sum >= (CFG_W + 1)'(n_eff)) ? pos_sum - (CFG_W + 1)'(n_eff) : pos_sum;
        n_pos    = PW'(pos_wrap);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_req.key == '0) ? S_EMIT : S_HOME;
                end
            end
            S_HOME: begin
                if (rem_rsp.done) begin
                    n_state = S_WRAP;
                end
            end
            S_WRAP: begin
                if (rem_rsp.done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (hit || empty || give_up) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_READ;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        i_req.ready      = 1'b0;
        rem_req.start    = 1'b0;
        rem_req.steps    = STEPS_HOME;
        rem_req.divisor  = d_eff;
        rem_req.dividend = i_req.key;
        mem_we           = 1'b0;
        mem_waddr        = AW'(r_pos);
        mem_wdata        = r_key;
        mem_raddr        = AW'(r_pos);
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            S_IDLE: begin
                i_req.ready   = 1'b1;
                rem_req.start = in_acc && (i_req.key != '0);
            end
            S_HOME: begin
                // Second pass folds the home slot into the slots in use.
                rem_req.start    = rem_rsp.done;
                rem_req.steps    = STEPS_WRAP;
                rem_req.divisor  = n_eff;
                rem_req.dividend = {rem_rsp.rem, (KEY_W - CFG_W)'(0)};
            end
            S_CHECK: begin
                mem_we = !hit && empty && r_func;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == S_EMIT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_func       <= i_req.func;
                    r_key        <= i_req.key;
                    r_res_status <= STAT_INVALID;
                    r_res_slot   <= '0;
                    r_res_probes <= '0;
                end
            end
            S_WRAP: begin
                if (rem_rsp.done) begin
                    r_pos  <= PW'(rem_rsp.rem);
                    r_coll <= '0;
                end
            end
            S_CHECK: begin
                r_res_slot   <= SLOT_W'(r_pos);
                r_res_probes <= r_coll;
                if (hit) begin
                    r_res_status <= STAT_FOUND;
                end else if (empty) begin
                    r_res_status <= r_func ? STAT_INSERTED : STAT_ABSENT;
                end else if (give_up) begin
                    r_res_status <= STAT_FULL;
                    r_res_probes <= coll_n;
                end else begin
                    r_pos  <= n_pos;
                    r_coll <= coll_n;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    r_o_status <= r_res_status;
                    r_o_slot   <= r_res_slot;
                    r_o_probes <= r_res_probes;
                end
            end
            default: begin
                r_func <= r_func;
            end
        endcase
    end

    assign o_rsp.valid  = r_ovalid;
    assign o_rsp.status = r_o_status;
    assign o_rsp.slot   = r_o_slot;
    assign o_rsp.probes = r_o_probes;

    `OAHT_ASSERT_IMP(a_write_only_empty, (r_state == S_CHECK) && mem_we,
                     (mem_rdata == '0) && r_func, "key written over an occupied slot")
    `OAHT_ASSERT_IMP(a_probe_in_range, r_state == S_READ,
                     (r_coll < n_eff) && (CFG_W'(r_pos) < n_eff),
                     "probe position or count out of range")
    `OAHT_ASSERT_NXT(a_emit_holds, (r_state == S_EMIT) && r_ovalid && !o_rsp.ready,
                     (r_state == S_EMIT) && r_ovalid,
                     "result word overwritten before it was taken")
endmodule

### sim/open_address_hash_table_tb.sv
module open_address_hash_table_tb;
    import oaht_pkg::*;

    localparam int DEPTH       = 128;
    localparam int CLK_HALF    = 4;
    localparam int RESET_LEN   = 12;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 50;
    localparam int DIR_ROWS    = 25;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic [APB_AW-1:0] ADDR_TABLE_SIZE = {REG_TABLE_SIZE, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_DIVISOR    = {REG_DIVISOR, 2'b00};

    typedef struct packed {
        t_status              status;
        logic [SLOT_W-1:0]    slot;
        logic [PROBE_W-1:0]   probes;
    } t_probe_result;

    typedef enum logic {ROW_ITEM, ROW_CONFIG} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic                 func;
        logic [KEY_W-1:0]     key;
        logic [CFG_W-1:0]     size_val;
        logic [CFG_W-1:0]     div_val;
        logic                 typed;
        t_probe_result        result;
    } t_dir_row;

    // Rows with typed results are zero keys or follow directly from an empty table.
    t_dir_row directed_rows [DIR_ROWS] = '{
        '{ROW_ITEM,   OP_LOOKUP, 31'd0,          8'd0,   8'd0,   1'b1, '{STAT_INVALID,  7'd0, 8'd0}},
        '{ROW_ITEM,   OP_INSERT, 31'd0,          8'd0,   8'd0,   1'b1, '{STAT_INVALID,  7'd0, 8'd0}},
        '{ROW_ITEM,   OP_LOOKUP, 31'd1,          8'd0,   8'd0,   1'b1, '{STAT_ABSENT,   7'd1, 8'd0}},
        '{ROW_ITEM,   OP_INSERT, 31'd1,          8'd0,   8'd0,   1'b1, '{STAT_INSERTED, 7'd1, 8'd0}},
        '{ROW_ITEM,   OP_LOOKUP, 31'd1,          8'd0,   8'd0,   1'b1, '{STAT_FOUND,    7'd1, 8'd0}},
        '{ROW_ITEM,   OP_INSERT, 31'd128,        8'd0,   8'd0,   1'b0, '0},
        '{ROW_ITEM,   OP_INSERT, 31'd255,        8'd0,   8'd0,   1'b0, '0},
        '{ROW_ITEM,   OP_INSERT, 31'h7FFF_FFFF,  8'd0,   8'd0,   1'b0, '0},
        '{ROW_ITEM,   OP_INSERT, 31'h2AAA_AAAA,  8'd0,   8'd0,   1'b0, '0},
        '{ROW_ITEM,   OP_INSERT, 31'h5555_5555,  8'd0,   8'd0,   1'b0, '0},
        '{ROW_ITEM,   OP_LOOKUP, 31'd382,        8'd0,   8'd0,   1'b0, '0},
        '{ROW_ITEM,   OP_INSERT, 31'd127,        8'd0,   8'd0,   1'b0, '0},
        '{ROW_CONFIG, OP_LOOKUP, 31'd0,          8'd0,   8'd0,   1'b0, '0},
        '{ROW_ITEM,   OP_LOOKUP, 31'd5,          8'd0,   8'd0,   1'b0, '0},
        '{ROW_ITEM,   OP_INSERT, 31'd127,        8'd0,   8'd0,   1'b0, '0},
        '{ROW_ITEM,   OP_LOOKUP, 31'd0,          8'd0,   8'd0,   1'b1, '{STAT_INVALID,  7'd0, 8'd0}},
        '{ROW_CONFIG, OP_LOOKUP, 31'd0,          8'd255, 8'd255, 1'b0, '0},
        '{ROW_ITEM,   OP_INSERT, 31'd254,        8'd0,   8'd0,   1'b0, '0},
        '{ROW_ITEM,   OP_LOOKUP, 31'h7FFF_FFFF,  8'd0,   8'd0,   1'b0, '0},
        '{ROW_CONFIG, OP_LOOKUP, 31'd0,          8'd2,   8'd2,   1'b0, '0},
        '{ROW_ITEM,   OP_INSERT, 31'd3,          8'd0,   8'd0,   1'b0, '0},
        '{ROW_ITEM,   OP_INSERT, 31'd2,          8'd0,   8'd0,   1'b0, '0},
        '{ROW_CONFIG, OP_LOOKUP, 31'd0,          8'd3,   8'd255, 1'b0, '0},
        '{ROW_ITEM,   OP_LOOKUP, 31'd200,        8'd0,   8'd0,   1'b0, '0},
        '{ROW_ITEM,   OP_INSERT, 31'd200,        8'd0,   8'd0,   1'b0, '0}
    };

    localparam logic [CFG_W-1:0] PHASE_SIZE [PHASES] = '{8'd128, 8'd16, 8'd2, 8'd255,
                                                        8'd16, 8'd0, 8'd0, 8'd128};
    localparam logic [CFG_W-1:0] PHASE_DIV  [PHASES] = '{8'd127, 8'd13, 8'd2, 8'd255,
                                                        8'd61, 8'd0, 8'd0, 8'd97};

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    oaht_req_if req_bus ();
    oaht_rsp_if rsp_bus ();

    open_address_hash_table #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the table and its registers.
    logic [KEY_W-1:0]    shadow_keys [DEPTH];
    logic [7:0]          shadow_count;
    logic [CFG_W-1:0]    shadow_size;
    logic [CFG_W-1:0]    shadow_div;

    t_probe_result       pending_results [$];
    logic [KEY_W-1:0]    stored_keys [$];
    int                  mismatch_count;
    int                  gap_pct;
    int                  stall_pct;

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    initial begin
        #(2 * CLK_HALF * 600000);
        $display("== FAIL ==");
        $finish;
    end

    function automatic t_probe_result probe_table(input logic op, input logic [KEY_W-1:0] key);
        int unsigned   n;
        int unsigned   d;
        int unsigned   pos;
        int unsigned   coll;
        int unsigned   k;
        t_probe_result res;
        res = '{STAT_INVALID, '0, '0};
        if (key == '0) begin
            return res;
        end
        n = (shadow_size == 0) ? 1 : ((shadow_size > DEPTH) ? DEPTH : shadow_size);
        d = (shadow_div == 0) ? 1 : shadow_div;
        k = key;
        pos = (k % d) % n;
        coll = 0;
        forever begin
            if (shadow_keys[pos] == key) begin
                res.status = STAT_FOUND;
                break;
            end
            if (shadow_keys[pos] == '0) begin
                if (op == OP_INSERT) begin
                    shadow_keys[pos] = key;
                    if (shadow_count != 8'd255) shadow_count = shadow_count + 8'd1;
                    res.status = STAT_INSERTED;
                end else begin
                    res.status = STAT_ABSENT;
                end
                break;
            end
            coll++;
            if (coll >= n) begin
                res.status = STAT_FULL;
                break;
            end
            // Triangular step: the offset from home grows by one more slot per collision.
            pos += coll;
            if (pos >= n) pos -= n;
        end
        res.slot = pos[SLOT_W-1:0];
        res.probes = coll[PROBE_W-1:0];
        return res;
    endfunction

    task automatic send_item(input logic op, input logic [KEY_W-1:0] key,
                             input logic typed, input t_probe_result typed_res);
        t_probe_result res;
        while ($urandom_range(99) < gap_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.func  <= op;
        req_bus.key   <= key;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        res = probe_table(op, key);
        pending_results.push_back(typed ? typed_res : res);
        if (res.status == STAT_INSERTED) stored_keys.push_back(key);
    endtask

    // Every item gives one word, so the block is idle once the queue has drained.
    task automatic wait_idle();
        req_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] size_val, input logic [CFG_W-1:0] div_val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TABLE_SIZE;
        pwdata  <= APB_DW'(size_val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        shadow_size = size_val;
        penable <= 1'b0;
        paddr   <= ADDR_DIVISOR;
        pwdata  <= APB_DW'(div_val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        shadow_div = div_val;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned r;
        logic [KEY_W-1:0] key;
        r = $urandom_range(99);
        if (r < 5) begin
            key = '0;
        end else if (r < 35 && stored_keys.size() != 0) begin
            key = stored_keys[$urandom_range(stored_keys.size() - 1)];
        end else if (r < 60) begin
            key = KEY_W'($urandom_range(1, 400));
        end else if (r < 65) begin
            key = 31'h7FFF_FFFF - KEY_W'($urandom_range(3));
        end else begin
            key = KEY_W'($urandom);
            if (key == '0) key = 31'd1;
        end
        return key;
    endfunction

    always @(posedge i_clk) begin
        rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_probe_result want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word status=%0d slot=%0d probes=%0d", $time,
                         rsp_bus.status, rsp_bus.slot, rsp_bus.probes);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (rsp_bus.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, rsp_bus.status);
                    mismatch_count++;
                end
                if (rsp_bus.slot !== want.slot) begin
                    $display("%0t: slot expected %0d actual %0d", $time,
                             want.slot, rsp_bus.slot);
                    mismatch_count++;
                end
                if (rsp_bus.probes !== want.probes) begin
                    $display("%0t: probes expected %0d actual %0d", $time,
                             want.probes, rsp_bus.probes);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        logic [CFG_W-1:0] size_val;
        logic [CFG_W-1:0] div_val;
        for (int i = 0; i < DEPTH; i++) shadow_keys[i] = '0;
        shadow_count   = '0;
        shadow_size    = 8'd128;
        shadow_div     = 8'd127;
        mismatch_count = 0;
        gap_pct        = 0;
        stall_pct      = 0;
        i_rst_n        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        req_bus.valid  <= 1'b0;
        req_bus.func   <= OP_LOOKUP;
        req_bus.key    <= '0;
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (directed_rows[i].kind == ROW_CONFIG) begin
                wait_idle();
                configure(directed_rows[i].size_val, directed_rows[i].div_val);
            end else begin
                send_item(directed_rows[i].func, directed_rows[i].key,
                          directed_rows[i].typed, directed_rows[i].result);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            size_val = PHASE_SIZE[p];
            div_val  = PHASE_DIV[p];
            // One phase runs under a random geometry with the divisor not above the size.
            if (p == 6) begin
                size_val = CFG_W'($urandom_range(2, DEPTH));
                div_val  = CFG_W'($urandom_range(2, size_val));
            end
            configure(size_val, div_val);
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 66; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 66; end
                default: begin gap_pct = 22; stall_pct = 22; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(($urandom_range(99) < 60) ? OP_INSERT : OP_LOOKUP, pick_key(),
                          1'b0, '0);
            end
        end

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
